[rtl/core/vna_pkg.sv]
package vna_pkg;

   localparam int VERTEX_COUNT = 1024;
   localparam int IDX_BITS     = $clog2(VERTEX_COUNT);
   localparam int COORD_BITS   = 16;
   localparam int ACCUM_BITS   = 48;
   localparam int CVAL_BITS    = COORD_BITS + 1;
   localparam int DIFF_BITS    = CVAL_BITS + 1;
   localparam int PROD_BITS    = 2 * DIFF_BITS;
   localparam int CROSS_BITS   = PROD_BITS + 1;
   localparam int NORM_BITS    = 16;

   // request codes
   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_TRI  = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   typedef enum logic [2:0] {
      L_IDLE,
      L_CLEAR,
      L_MULA,
      L_MULB,
      L_READ,
      L_ADD
   } lane_op_type;

   typedef struct packed {
      lane_op_type         op;
      logic [IDX_BITS-1:0] addr;
   } lane_ctrl_type;

   typedef struct packed {
      logic start;
      logic ack;
   } norm_ctrl_type;

   // Q8.8 as is, or byte u scaled to Q8.8: (u*256+127)/255 == u + (u >= 128)
   function automatic logic signed [CVAL_BITS-1:0] coord_value(
      input logic [COORD_BITS-1:0] raw,
      input logic                  fmt
   );
      logic [8:0] scaled;
      scaled = {1'b0, raw[7:0]} + {8'd0, raw[7]};
      if (fmt) begin
         coord_value = signed'({{(CVAL_BITS-9){1'b0}}, scaled});
      end else begin
         coord_value = signed'({raw[COORD_BITS-1], raw});
      end
   endfunction

endpackage

[rtl/core/vna_lane.sv]
module vna_lane (
   input  logic                                 clock,
   input  vna_pkg::lane_ctrl_type               ctrl,
   input  logic signed [vna_pkg::DIFF_BITS-1:0] op_a1,
   input  logic signed [vna_pkg::DIFF_BITS-1:0] op_a2,
   input  logic signed [vna_pkg::DIFF_BITS-1:0] op_b1,
   input  logic signed [vna_pkg::DIFF_BITS-1:0] op_b2,
   output logic signed [vna_pkg::ACCUM_BITS-1:0] sum_q
);
   import vna_pkg::*;

   localparam logic signed [ACCUM_BITS:0] SAT_MAX =
      signed'({2'b00, {(ACCUM_BITS-1){1'b1}}});
   localparam logic signed [ACCUM_BITS:0] SAT_MIN = -SAT_MAX;

   logic signed [ACCUM_BITS-1:0] sum_mem [VERTEX_COUNT];
   logic signed [PROD_BITS-1:0]  prod_a_ff;
   logic signed [CROSS_BITS-1:0] cross_ff;
   logic signed [ACCUM_BITS-1:0] sum_q_ff;
   logic signed [ACCUM_BITS:0]   sum_wide;
   logic signed [ACCUM_BITS-1:0] sum_sat;

   assign sum_q = sum_q_ff;

   // saturating add of the cross component
   always_comb begin
      sum_wide = {sum_q_ff[ACCUM_BITS-1], sum_q_ff}
               + {{(ACCUM_BITS+1-CROSS_BITS){cross_ff[CROSS_BITS-1]}}, cross_ff};
      if (sum_wide > SAT_MAX) begin
         sum_sat = SAT_MAX[ACCUM_BITS-1:0];
      end else if (sum_wide < SAT_MIN) begin
         sum_sat = SAT_MIN[ACCUM_BITS-1:0];
      end else begin
         sum_sat = sum_wide[ACCUM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         L_IDLE: begin
         end
         L_CLEAR: begin
            sum_mem[ctrl.addr] <= '0;
         end
         L_MULA: begin
            prod_a_ff <= op_a1 * op_a2;
         end
         L_MULB: begin
            cross_ff <= {prod_a_ff[PROD_BITS-1], prod_a_ff}
                      - {{1{1'b0}} ^ 1'b0, {PROD_BITS{1'b0}}}
                      - CROSS_BITS'(op_b1 * op_b2);
         end
         L_READ: begin
            sum_q_ff <= sum_mem[ctrl.addr];
         end
         L_ADD: begin
            sum_mem[ctrl.addr] <= sum_sat;
         end
         default: begin
         end
      endcase
   end

endmodule

[rtl/core/vna_norm.sv]
module vna_norm (
   input  logic                                  clock,
   input  logic                                  reset,
   input  vna_pkg::norm_ctrl_type                ctrl,
   input  logic signed [vna_pkg::ACCUM_BITS-1:0] sum_x,
   input  logic signed [vna_pkg::ACCUM_BITS-1:0] sum_y,
   input  logic signed [vna_pkg::ACCUM_BITS-1:0] sum_z,
   output logic                                  done,
   output logic signed [vna_pkg::NORM_BITS-1:0]  norm_x,
   output logic signed [vna_pkg::NORM_BITS-1:0]  norm_y,
   output logic signed [vna_pkg::NORM_BITS-1:0]  norm_z,
   output logic                                  zero
);
   import vna_pkg::*;

   typedef enum logic [2:0] {
      N_IDLE,
      N_SHIFT,
      N_SQ,
      N_SQRT,
      N_DLOAD,
      N_DIV,
      N_FIN,
      N_DONE
   } nstate_type;

   localparam logic [NORM_BITS-1:0] ONE = NORM_BITS'(16384);

   nstate_type                  state_ff;
   logic [ACCUM_BITS-1:0]       m_ff [3];
   logic [2:0]                  neg_ff;
   logic [61:0]                 sq_ff;
   logic [61:0]                 v_ff;
   logic [32:0]                 rem_ff;
   logic [30:0]                 root_ff;
   logic [4:0]                  cnt_ff;
   logic [1:0]                  comp_ff;
   logic [32:0]                 drem_ff;
   logic [15:0]                 nb_ff;
   logic [15:0]                 q_ff;
   logic signed [NORM_BITS-1:0] n_ff [3];
   logic                        zero_ff;

   logic                        big, tiny;
   logic [59:0]                 sq_prod;
   logic [34:0]                 trial_rem, trial;
   logic [44:0]                 num_in;
   logic [32:0]                 r2;
   logic [NORM_BITS-1:0]        qc;

   always_comb begin
      big   = (|m_ff[0][ACCUM_BITS-1:30]) | (|m_ff[1][ACCUM_BITS-1:30])
            | (|m_ff[2][ACCUM_BITS-1:30]);
      tiny  = ~((|m_ff[0][ACCUM_BITS-1:29]) | (|m_ff[1][ACCUM_BITS-1:29])
            | (|m_ff[2][ACCUM_BITS-1:29]));
      sq_prod   = m_ff[comp_ff][29:0] * m_ff[comp_ff][29:0];
      trial_rem = {rem_ff, v_ff[61:60]};
      trial     = {2'b00, root_ff, 2'b01};
      num_in    = {1'b0, m_ff[comp_ff][29:0], 14'd0} + {15'd0, root_ff[30:1]};
      r2        = {drem_ff[31:0], nb_ff[15]};
      qc        = (q_ff > ONE) ? ONE : q_ff;
   end

   assign done   = (state_ff == N_DONE);
   assign norm_x = n_ff[0];
   assign norm_y = n_ff[1];
   assign norm_z = n_ff[2];
   assign zero   = zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         unique case (state_ff)
            N_IDLE: begin
               if (ctrl.start) begin
                  m_ff[0] <= sum_x[ACCUM_BITS-1] ? ACCUM_BITS'(-sum_x) : sum_x;
                  m_ff[1] <= sum_y[ACCUM_BITS-1] ? ACCUM_BITS'(-sum_y) : sum_y;
                  m_ff[2] <= sum_z[ACCUM_BITS-1] ? ACCUM_BITS'(-sum_z) : sum_z;
                  neg_ff  <= {sum_z[ACCUM_BITS-1], sum_y[ACCUM_BITS-1],
                              sum_x[ACCUM_BITS-1]};
                  if (sum_x == '0 && sum_y == '0 && sum_z == '0) begin
                     zero_ff  <= 1'b1;
                     n_ff[0]  <= '0;
                     n_ff[1]  <= '0;
                     n_ff[2]  <= '0;
                     state_ff <= N_DONE;
                  end else begin
                     zero_ff  <= 1'b0;
                     state_ff <= N_SHIFT;
                  end
               end
            end
            N_SHIFT: begin
               // bring the largest magnitude into [2^29, 2^30), one bit a cycle
               if (big) begin
                  m_ff[0] <= m_ff[0] >> 1;
                  m_ff[1] <= m_ff[1] >> 1;
                  m_ff[2] <= m_ff[2] >> 1;
               end else if (tiny) begin
                  m_ff[0] <= m_ff[0] << 1;
                  m_ff[1] <= m_ff[1] << 1;
                  m_ff[2] <= m_ff[2] << 1;
               end else begin
                  sq_ff    <= '0;
                  comp_ff  <= '0;
                  state_ff <= N_SQ;
               end
            end
            N_SQ: begin
               sq_ff <= sq_ff + {2'b00, sq_prod};
               if (comp_ff == 2'd2) begin
                  v_ff     <= sq_ff + {2'b00, sq_prod};
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= '0;
                  comp_ff  <= '0;
                  state_ff <= N_SQRT;
               end else begin
                  comp_ff <= comp_ff + 2'd1;
               end
            end
            N_SQRT: begin
               if (trial_rem >= trial) begin
                  rem_ff  <= 33'(trial_rem - trial);
                  root_ff <= {root_ff[29:0], 1'b1};
               end else begin
                  rem_ff  <= trial_rem[32:0];
                  root_ff <= {root_ff[29:0], 1'b0};
               end
               v_ff   <= v_ff << 2;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd30) begin
                  state_ff <= N_DLOAD;
               end
            end
            N_DLOAD: begin
               drem_ff  <= {4'd0, num_in[44:16]};
               nb_ff    <= num_in[15:0];
               q_ff     <= '0;
               cnt_ff   <= '0;
               state_ff <= N_DIV;
            end
            N_DIV: begin
               if (r2 >= {2'b00, root_ff}) begin
                  drem_ff <= r2 - {2'b00, root_ff};
                  q_ff    <= {q_ff[14:0], 1'b1};
               end else begin
                  drem_ff <= r2;
                  q_ff    <= {q_ff[14:0], 1'b0};
               end
               nb_ff  <= nb_ff << 1;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd15) begin
                  state_ff <= N_FIN;
               end
            end
            N_FIN: begin
               n_ff[comp_ff] <= neg_ff[comp_ff] ? signed'(-qc) : signed'(qc);
               if (comp_ff == 2'd2) begin
                  state_ff <= N_DONE;
               end else begin
                  comp_ff  <= comp_ff + 2'd1;
                  state_ff <= N_DLOAD;
               end
            end
            N_DONE: begin
               if (ctrl.ack) begin
                  state_ff <= N_IDLE;
               end
            end
            default: begin
               state_ff <= N_IDLE;
            end
         endcase
      end
   end

endmodule

[rtl/core/vertex_normal_accumulator.sv]
// Channel   | Direction | Handshake           | Payload
// req_      | in        | req_valid/req_stall | req_type, corner a/b/c, coord x/y/z
// rsp_      | out       | rsp_valid/rsp_stall | vertex_id, normal x/y/z, zero_normal
// csr_      | in        | csr_we              | csr_wdata (coord_format)
//
// Load: the position is written and the vertex's sums cleared as it is accepted;
// the block stays idle. Triangle: three position reads, two multiply steps,
// three sum read-modify-writes on the single port of each lane's memory.
// Read: the normalizer runs the one-bit-a-cycle normalizing shift, the 31-step
// square root and three 16-step divisions, all skipped for a zero sum.
// After reset a clearing pass zeroes the sums of all 1024 vertices; no request is
// taken meanwhile. A finished result waits in the output register under stall
// while the next request is taken.
module vertex_normal_accumulator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_type,
   input  logic [vna_pkg::IDX_BITS-1:0]        req_corner_a,
   input  logic [vna_pkg::IDX_BITS-1:0]        req_corner_b,
   input  logic [vna_pkg::IDX_BITS-1:0]        req_corner_c,
   input  logic signed [vna_pkg::COORD_BITS-1:0] req_coord_x,
   input  logic signed [vna_pkg::COORD_BITS-1:0] req_coord_y,
   input  logic signed [vna_pkg::COORD_BITS-1:0] req_coord_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [vna_pkg::IDX_BITS-1:0]        rsp_vertex_id,
   output logic signed [vna_pkg::NORM_BITS-1:0] rsp_normal_x,
   output logic signed [vna_pkg::NORM_BITS-1:0] rsp_normal_y,
   output logic signed [vna_pkg::NORM_BITS-1:0] rsp_normal_z,
   output logic                                rsp_zero_normal,
   input  logic                                csr_we,
   input  logic                                csr_wdata
);
   import vna_pkg::*;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_TA, S_TB, S_TC, S_TD, S_M1, S_M2,
      S_R0, S_W0, S_R1, S_W1, S_R2, S_W2, S_RR, S_NORM
   } state_type;

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(VERTEX_COUNT - 1);

   state_type                     state_ff;
   logic                          fmt_ff;
   logic [IDX_BITS-1:0]           clr_cnt_ff;
   logic [IDX_BITS-1:0]           ia_ff, ib_ff, ic_ff;
   logic [3*COORD_BITS-1:0]       pos_mem [VERTEX_COUNT];
   logic [3*COORD_BITS-1:0]       pos_q_ff;
   logic [IDX_BITS-1:0]           pos_addr;
   logic signed [CVAL_BITS-1:0]   p0_ff [3];
   logic signed [CVAL_BITS-1:0]   pv [3];
   logic signed [DIFF_BITS-1:0]   d1_ff [3];
   logic signed [DIFF_BITS-1:0]   d2_ff [3];
   lane_ctrl_type                 lane_ctrl;
   norm_ctrl_type                 norm_ctrl;
   logic signed [ACCUM_BITS-1:0]  sum_q [3];
   logic                          norm_done, norm_zero;
   logic signed [NORM_BITS-1:0]   nx, ny, nz;
   logic                          accept, rsp_free;
   logic                          rsp_valid_ff;
   logic [IDX_BITS-1:0]           rsp_id_ff;
   logic signed [NORM_BITS-1:0]   rsp_nx_ff, rsp_ny_ff, rsp_nz_ff;
   logic                          rsp_zero_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   // convert the raw position word that the memory returns
   always_comb begin
      pv[0] = coord_value(pos_q_ff[COORD_BITS-1:0], fmt_ff);
      pv[1] = coord_value(pos_q_ff[2*COORD_BITS-1:COORD_BITS], fmt_ff);
      pv[2] = coord_value(pos_q_ff[3*COORD_BITS-1:2*COORD_BITS], fmt_ff);
   end

   // position port address, lane commands and normalizer handshake per state
   always_comb begin
      pos_addr       = ia_ff;
      lane_ctrl.op   = L_IDLE;
      lane_ctrl.addr = ia_ff;
      norm_ctrl      = '0;
      unique case (state_ff)
         S_CLR: begin
            lane_ctrl.op   = L_CLEAR;
            lane_ctrl.addr = clr_cnt_ff;
         end
         S_IDLE: begin
            if (accept && req_type == REQ_LOAD) begin
               lane_ctrl.op   = L_CLEAR;
               lane_ctrl.addr = req_corner_a;
            end
         end
         S_TA: pos_addr = ia_ff;
         S_TB: pos_addr = ib_ff;
         S_TC: pos_addr = ic_ff;
         S_TD: begin
         end
         S_M1: lane_ctrl.op = L_MULA;
         S_M2: lane_ctrl.op = L_MULB;
         S_R0: lane_ctrl.op = L_READ;
         S_W0: lane_ctrl.op = L_ADD;
         S_R1: begin
            lane_ctrl.op   = L_READ;
            lane_ctrl.addr = ib_ff;
         end
         S_W1: begin
            lane_ctrl.op   = L_ADD;
            lane_ctrl.addr = ib_ff;
         end
         S_R2: begin
            lane_ctrl.op   = L_READ;
            lane_ctrl.addr = ic_ff;
         end
         S_W2: begin
            lane_ctrl.op   = L_ADD;
            lane_ctrl.addr = ic_ff;
         end
         S_RR: begin
            lane_ctrl.op    = L_READ;
         end
         S_NORM: begin
            norm_ctrl.start = 1'b0;
            norm_ctrl.ack   = norm_done & rsp_free;
         end
         default: begin
         end
      endcase
   end

   // sums are read in S_RR; start the normalizer on the cycle after it
   logic start_ff;
   logic start_in;
   assign start_in = (state_ff == S_RR);

   // position memory: write on load, read every cycle
   always_ff @(posedge clock) begin
      if (accept && req_type == REQ_LOAD) begin
         pos_mem[req_corner_a] <= {req_coord_z, req_coord_y, req_coord_x};
      end
      pos_q_ff <= pos_mem[pos_addr];
   end

   // lane x: dy*dz', lane y: dz*dx', lane z: dx*dy'
   vna_lane u_lane_x (
      .clock (clock), .ctrl (lane_ctrl),
      .op_a1 (d1_ff[1]), .op_a2 (d2_ff[2]), .op_b1 (d1_ff[2]), .op_b2 (d2_ff[1]),
      .sum_q (sum_q[0])
   );
   vna_lane u_lane_y (
      .clock (clock), .ctrl (lane_ctrl),
      .op_a1 (d1_ff[2]), .op_a2 (d2_ff[0]), .op_b1 (d1_ff[0]), .op_b2 (d2_ff[2]),
      .sum_q (sum_q[1])
   );
   vna_lane u_lane_z (
      .clock (clock), .ctrl (lane_ctrl),
      .op_a1 (d1_ff[0]), .op_a2 (d2_ff[1]), .op_b1 (d1_ff[1]), .op_b2 (d2_ff[0]),
      .sum_q (sum_q[2])
   );

   norm_ctrl_type norm_go;
   always_comb begin
      norm_go       = norm_ctrl;
      norm_go.start = start_ff;
   end

   // merge: normalize the three lane sums
   vna_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (norm_go),
      .sum_x  (sum_q[0]),
      .sum_y  (sum_q[1]),
      .sum_z  (sum_q[2]),
      .done   (norm_done),
      .norm_x (nx),
      .norm_y (ny),
      .norm_z (nz),
      .zero   (norm_zero)
   );

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ia_ff <= req_corner_a;
         ib_ff <= req_corner_b;
         ic_ff <= req_corner_c;
      end
      if (state_ff == S_TB) begin
         p0_ff <= pv;
      end
      if (state_ff == S_TC) begin
         for (int i = 0; i < 3; i++) begin
            d1_ff[i] <= DIFF_BITS'(pv[i]) - DIFF_BITS'(p0_ff[i]);
         end
      end
      if (state_ff == S_TD) begin
         for (int i = 0; i < 3; i++) begin
            d2_ff[i] <= DIFF_BITS'(pv[i]) - DIFF_BITS'(p0_ff[i]);
         end
      end
      if (norm_ctrl.ack) begin
         rsp_id_ff   <= ia_ff;
         rsp_nx_ff   <= nx;
         rsp_ny_ff   <= ny;
         rsp_nz_ff   <= nz;
         rsp_zero_ff <= norm_zero;
      end
   end

   // control: sequencer, clearing pass, config, response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_cnt_ff   <= '0;
         fmt_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= 1'b0;
      end else begin
         start_ff <= start_in;
         if (csr_we) begin
            fmt_ff <= csr_wdata;
         end
         if (norm_ctrl.ack) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLR: begin
               clr_cnt_ff <= clr_cnt_ff + IDX_BITS'(1);
               if (clr_cnt_ff == LAST_IDX) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  priority case (req_type)
                     REQ_TRI:  state_ff <= S_TA;
                     REQ_READ: state_ff <= S_RR;
                     default:  state_ff <= S_IDLE;
                  endcase
               end
            end
            S_TA:   state_ff <= S_TB;
            S_TB:   state_ff <= S_TC;
            S_TC:   state_ff <= S_TD;
            S_TD:   state_ff <= S_M1;
            S_M1:   state_ff <= S_M2;
            S_M2:   state_ff <= S_R0;
            S_R0:   state_ff <= S_W0;
            S_W0:   state_ff <= S_R1;
            S_R1:   state_ff <= S_W1;
            S_W1:   state_ff <= S_R2;
            S_R2:   state_ff <= S_W2;
            S_W2:   state_ff <= S_IDLE;
            S_RR:   state_ff <= S_NORM;
            S_NORM: begin
               // hold until the normalizer is done and the result register is free
               if (norm_ctrl.ack) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_vertex_id   = rsp_id_ff;
   assign rsp_normal_x    = rsp_nx_ff;
   assign rsp_normal_y    = rsp_ny_ff;
   assign rsp_normal_z    = rsp_nz_ff;
   assign rsp_zero_normal = rsp_zero_ff;

endmodule

[rtl/core/vna_checker.sv]
module vna_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic [1:0]                            req_type,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [vna_pkg::IDX_BITS-1:0]          rsp_vertex_id,
   input logic signed [vna_pkg::NORM_BITS-1:0]  rsp_normal_x,
   input logic signed [vna_pkg::NORM_BITS-1:0]  rsp_normal_y,
   input logic signed [vna_pkg::NORM_BITS-1:0]  rsp_normal_z,
   input logic                                  rsp_zero_normal
);
   import vna_pkg::*;

   // a zero flag comes with zero components
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_normal) |->
      (rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0))
      else $error("zero_normal with nonzero components");

   // components stay within unit range
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x <= 16'sd16384 && rsp_normal_x >= -16'sd16384 &&
                     rsp_normal_y <= 16'sd16384 && rsp_normal_y >= -16'sd16384 &&
                     rsp_normal_z <= 16'sd16384 && rsp_normal_z >= -16'sd16384))
      else $error("normal component out of range");

   // a triangle or read request occupies the block: stall right after it
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_type == REQ_TRI || req_type == REQ_READ))
      |=> req_stall)
      else $error("request taken back to back");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_vertex_id) &&
                                    $stable(rsp_normal_x)))
      else $error("stalled response changed");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_type        (req_type),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_vertex_id   (rsp_vertex_id),
   .rsp_normal_x    (rsp_normal_x),
   .rsp_normal_y    (rsp_normal_y),
   .rsp_normal_z    (rsp_normal_z),
   .rsp_zero_normal (rsp_zero_normal)
);

[bench/vertex_normal_accumulator_test.sv]
module vertex_normal_accumulator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import vna_pkg::*;

   // request code the block ignores
   localparam logic [1:0] REQ_IDLE_CODE = 2'd3;
   localparam longint SUM_LIMIT = (longint'(1) <<< (ACCUM_BITS - 1)) - 1;

   typedef struct {
      logic [1:0]                  kind;
      logic [IDX_BITS-1:0]         a, b, c;
      logic signed [COORD_BITS-1:0] x, y, z;
   } request_type;

   typedef struct {
      logic [IDX_BITS-1:0]         id;
      logic signed [NORM_BITS-1:0] nx, ny, nz;
      logic                        zero;
   } normal_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_type = '0;
   logic [IDX_BITS-1:0] req_corner_a = '0, req_corner_b = '0, req_corner_c = '0;
   logic signed [COORD_BITS-1:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [IDX_BITS-1:0] rsp_vertex_id;
   logic signed [NORM_BITS-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_zero_normal;
   logic csr_we = 1'b0;
   logic csr_wdata = 1'b0;

   vertex_normal_accumulator i_dut (.*);

   // period 12 ns
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state: raw positions, saturating sums and the coordinate format
   logic [COORD_BITS-1:0] pos_raw [VERTEX_COUNT][3];
   longint                sum_acc [VERTEX_COUNT][3];
   bit                    loaded  [VERTEX_COUNT];
   logic                  byte_mode = 1'b0;

   request_type request_queue[$];
   normal_type  pending_normals[$];
   request_type cur_req;
   bit       req_taken = 0;
   bit       calm_send = 0, calm_recv = 0;
   int       send_gap = 0, recv_gap = 0;
   int       fail_count = 0;

   function automatic longint coord_of(logic [COORD_BITS-1:0] raw);
      if (byte_mode)
         return (longint'(raw[7:0]) * 256 + 127) / 255;
      return longint'(signed'(raw));
   endfunction

   function automatic longint sat_sum(longint s, longint d);
      if (d > 0 && s > SUM_LIMIT - d) return SUM_LIMIT;
      if (d < 0 && s < -SUM_LIMIT - d) return -SUM_LIMIT;
      return s + d;
   endfunction

   function automatic normal_type unit_normal(logic [IDX_BITS-1:0] id, longint s[3]);
      normal_type r;
      longint unsigned m[3], mx, sq, len, bitv, q;
      r.id = id; r.nx = 0; r.ny = 0; r.nz = 0; r.zero = 1'b1;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = s[i] < 0 ? longint'(-s[i]) : longint'(s[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return r;
      r.zero = 1'b0;
      while (mx >= (64'd1 << 30)) begin
         mx >>= 1;
         for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      // bitwise integer square root, floor
      len = 0;
      bitv = 64'd1 << 62;
      while (bitv > sq) bitv >>= 2;
      while (bitv != 0) begin
         if (sq >= len + bitv) begin
            sq -= len + bitv;
            len = (len >> 1) + bitv;
         end else begin
            len >>= 1;
         end
         bitv >>= 2;
      end
      for (int i = 0; i < 3; i++) begin
         q = (m[i] * 16384 + len / 2) / len;
         if (q > 16384) q = 16384;
         m[i] = s[i] < 0 ? -q : q;
      end
      r.nx = m[0][15:0]; r.ny = m[1][15:0]; r.nz = m[2][15:0];
      return r;
   endfunction

   // advance the predictor by one accepted request
   task automatic apply_request(request_type rq);
      longint p[3][3], d1[3], d2[3], cr[3];
      logic [IDX_BITS-1:0] idx[3];
      case (rq.kind)
         REQ_LOAD: begin
            pos_raw[rq.a][0] = rq.x; pos_raw[rq.a][1] = rq.y; pos_raw[rq.a][2] = rq.z;
            for (int j = 0; j < 3; j++) sum_acc[rq.a][j] = 0;
         end
         REQ_TRI: begin
            idx[0] = rq.a; idx[1] = rq.b; idx[2] = rq.c;
            for (int k = 0; k < 3; k++)
               for (int j = 0; j < 3; j++) p[k][j] = coord_of(pos_raw[idx[k]][j]);
            for (int j = 0; j < 3; j++) begin
               d1[j] = p[1][j] - p[0][j];
               d2[j] = p[2][j] - p[0][j];
            end
            cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
            cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
            cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
            // repeated corners collect the product once per corner
            for (int k = 0; k < 3; k++)
               for (int j = 0; j < 3; j++)
                  sum_acc[idx[k]][j] = sat_sum(sum_acc[idx[k]][j], cr[j]);
         end
         REQ_READ: pending_normals.push_back(unit_normal(rq.a, sum_acc[rq.a]));
         default: ;
      endcase
   endtask

   function automatic int pick_gap(bit calm);
      if (calm || $urandom_range(0, 2) != 0) return 0;
      if ($urandom_range(0, 11) == 0) return $urandom_range(15, 60);
      return $urandom_range(1, 3);
   endfunction

   // take the request on the rising edge, feed the predictor
   always @(posedge clock) begin
      req_taken = 0;
      if (!reset && req_valid && !req_stall) begin
         apply_request(cur_req);
         req_taken = 1;
      end
   end

   // request driver: hold while stalled, otherwise idle a while or present the next
   always @(negedge clock) begin
      logic nv;
      nv = req_valid;
      if (!reset && (!req_valid || req_taken)) begin
         if (req_taken) send_gap = pick_gap(calm_send);
         nv = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (request_queue.size() > 0) begin
            cur_req = request_queue.pop_front();
            req_type <= cur_req.kind;
            req_corner_a <= cur_req.a;
            req_corner_b <= cur_req.b;
            req_corner_c <= cur_req.c;
            req_coord_x <= cur_req.x;
            req_coord_y <= cur_req.y;
            req_coord_z <= cur_req.z;
            nv = 1'b1;
         end
      end
      req_valid <= nv;
   end

   // response side back-pressure
   always @(negedge clock) begin
      if (recv_gap > 0) begin
         recv_gap--;
         rsp_stall <= 1'b1;
      end else begin
         recv_gap = pick_gap(calm_recv);
         rsp_stall <= recv_gap > 0;
      end
   end

   // compare each returned normal with the oldest prediction
   always @(posedge clock) begin
      normal_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_normals.size() == 0) begin
            $error("unexpected response for vertex %0d", rsp_vertex_id);
            fail_count++;
         end else begin
            e = pending_normals.pop_front();
            if (rsp_vertex_id !== e.id) begin
               $error("vertex_id exp %0d got %0d", e.id, rsp_vertex_id); fail_count++;
            end
            if (rsp_normal_x !== e.nx) begin
               $error("normal_x exp %0d got %0d", e.nx, rsp_normal_x); fail_count++;
            end
            if (rsp_normal_y !== e.ny) begin
               $error("normal_y exp %0d got %0d", e.ny, rsp_normal_y); fail_count++;
            end
            if (rsp_normal_z !== e.nz) begin
               $error("normal_z exp %0d got %0d", e.nz, rsp_normal_z); fail_count++;
            end
            if (rsp_zero_normal !== e.zero) begin
               $error("zero_normal exp %0d got %0d", e.zero, rsp_zero_normal);
               fail_count++;
            end
         end
      end
   end

   task automatic push_req(logic [1:0] k, int a, int b, int c,
                           int x = 0, int y = 0, int z = 0);
      request_type r;
      r.kind = k;
      r.a = IDX_BITS'(a); r.b = IDX_BITS'(b); r.c = IDX_BITS'(c);
      r.x = COORD_BITS'(x); r.y = COORD_BITS'(y); r.z = COORD_BITS'(z);
      // only triangles on loaded corners; a load marks its vertex
      if (k == REQ_LOAD) loaded[a] = 1;
      request_queue.push_back(r);
   endtask

   // drain all requests and results, then let a triangle in flight finish
   task automatic wait_idle();
      while (request_queue.size() > 0 || req_valid || pending_normals.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_format(logic v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      byte_mode = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int rand_coord();
      case ($urandom_range(0, 5))
         0: return 32767;
         1: return -32768;
         2: return $urandom_range(0, 255);
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   task automatic random_phase(int count);
      int base, v[3], n;
      base = $urandom_range(0, VERTEX_COUNT - 12);
      calm_send = $urandom_range(0, 3) == 0;
      calm_recv = $urandom_range(0, 3) == 0;
      n = 0;
      while (n < count) begin
         for (int k = 0; k < 3; k++) v[k] = base + $urandom_range(0, 11);
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:
               push_req(REQ_LOAD, v[0], $urandom_range(0, 1023), $urandom_range(0, 1023),
                        rand_coord(), rand_coord(), rand_coord());
            6, 7, 8, 9, 10, 11, 12, 13: begin
               if ($urandom_range(0, 9) == 0) v[1] = v[0];
               if (loaded[v[0]] && loaded[v[1]] && loaded[v[2]])
                  push_req(REQ_TRI, v[0], v[1], v[2]);
               else
                  push_req(REQ_LOAD, v[0], 0, 0, rand_coord(), rand_coord(), rand_coord());
            end
            14, 15, 16, 17, 18:
               push_req(REQ_READ, $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                        : v[0], $urandom_range(0, 1023), $urandom_range(0, 1023));
            default:
               push_req(REQ_IDLE_CODE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
         endcase
         n++;
      end
      wait_idle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, each request kind, degenerate and repeated corners
      write_format(1'b0);
      push_req(REQ_READ, 1023, 0, 0);
      push_req(REQ_LOAD, 0, 0, 0, -32768, -32768, -32768);
      push_req(REQ_LOAD, 1, 1023, 1023, 32767, -32768, 0);
      push_req(REQ_LOAD, 2, 0, 0, -32768, 32767, 32767);
      push_req(REQ_LOAD, 1023, 0, 0, 32767, 32767, 32767);
      push_req(REQ_TRI, 0, 1, 2);
      push_req(REQ_TRI, 1023, 2, 1);
      push_req(REQ_READ, 0, 0, 0);
      push_req(REQ_READ, 1, 0, 0);
      push_req(REQ_READ, 1023, 0, 0);
      push_req(REQ_TRI, 0, 0, 1);
      push_req(REQ_TRI, 2, 2, 2);
      push_req(REQ_READ, 2, 0, 0);
      push_req(REQ_IDLE_CODE, 1023, 1023, 1023, -1, -1, -1);
      push_req(REQ_LOAD, 0, 0, 0, 1, 0, 0);
      push_req(REQ_READ, 0, 0, 0);
      wait_idle();
      write_format(1'b1);
      push_req(REQ_TRI, 0, 1, 2);
      push_req(REQ_TRI, 1, 2, 1023);
      push_req(REQ_READ, 0, 0, 0);
      push_req(REQ_READ, 1, 0, 0);
      push_req(REQ_READ, 2, 0, 0);
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         write_format(ph[0]);
         random_phase(ph == 7 ? 10 : 205);
      end

      repeat (150) @(posedge clock);
      if (fail_count == 0 && pending_normals.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
